// ===== design/csv_field_splitter_core_macros.svh =====
// Assertion macros for the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication under reset disable.
`define CSVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under reset disable.
`define CSVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CSVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/csvs_pkg.sv =====
// Shared constants and codes of the CSV field splitter.
package csvs_pkg;

  // Sizing
  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned LINE_BYTES  = 65536;

  // Line store holds at most 65535 bytes (16-bit positions).
  localparam int unsigned STORE_CAP   = (LINE_BYTES < 65535) ? LINE_BYTES : 65535;
  localparam logic [15:0] STORE_LIMIT = STORE_CAP[15:0];

  // Field index cap: the 8-bit field counter allows at most 256 columns.
  localparam int unsigned COL_CAP       = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam logic [8:0]  COL_LIMIT_MAX = COL_CAP[8:0];

  // Config port
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COLUMNS = 4'd1;

  localparam logic [7:0] SEPARATOR_RESET        = 8'd44;
  localparam logic [8:0] EXPECTED_COLUMNS_RESET = 9'd1;

  // Result kinds
  localparam logic [3:0] KIND_DATA       = 4'd0;
  localparam logic [3:0] KIND_FIELD_END  = 4'd1;
  localparam logic [3:0] KIND_LINE_OK    = 4'd2;
  localparam logic [3:0] KIND_LINE_BAD   = 4'd3;
  localparam logic [3:0] KIND_NL_QUOTE   = 4'd4;
  localparam logic [3:0] KIND_TOO_MANY   = 4'd5;
  localparam logic [3:0] KIND_TOO_LONG   = 4'd6;
  localparam logic [3:0] KIND_EOF_OK     = 4'd7;
  localparam logic [3:0] KIND_EOF_BAD    = 4'd8;

  // Special bytes
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

endpackage

// ===== design/csvs_if.sv =====
// Channel interfaces of the CSV field splitter: byte in, result out, config write.
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  char_value;
  logic [15:0] line_position;
  logic [7:0]  field_number;
  logic [15:0] field_start;
  logic [15:0] field_size;

  modport source (output valid, output kind, output char_value, output line_position,
                  output field_number, output field_start, output field_size,
                  input ready);
  modport sink   (input valid, input kind, input char_value, input line_position,
                  input field_number, input field_start, input field_size,
                  output ready);
endinterface

interface csvs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csvs_pkg::CFG_IDX_W-1:0] reg_index;
  logic [csvs_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/csv_field_splitter_core.sv =====
// Top level of the CSV field splitter: byte-serial line tokenizer.
//
//  channel | dir | words carried                     | accepted when
//  --------+-----+-----------------------------------+-------------------
//  in_i    | in  | data_byte, end_of_input           | valid && ready
//  out_o   | out | kind, char, position, field info  | valid && ready
//  cfg_i   | in  | reg_index, wdata                  | valid && ready
//
//  One word per cycle sustained while the result register is drained.
//  Path: input register -> byte classify / state update -> result register.
//  Words that give no result (quotes, CR) retire without needing result space.
//  A full result register stalls only words that produce a result.
//  Reset (rst_ni low) clears line state, valids and restores config defaults.
//  cfg_i is always ready; writes are meant for idle periods only.
`include "csv_field_splitter_core_macros.svh"

module csv_field_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  csvs_in_if.sink     in_i,
  csvs_out_if.source  out_o,
  csvs_cfg_if.sink    cfg_i
);

  // Config registers
  logic [7:0] sep_q;
  logic [8:0] expcol_q;

  // Line state
  logic        inq_q,    inq_d;
  logic [7:0]  field_q,  field_d;
  logic [15:0] flen_q,   flen_d;
  logic [15:0] fstart_q, fstart_d;
  logic [15:0] wpos_q,   wpos_d;

  // Input register
  logic       ivalid_q, ivalid_d;
  logic [7:0] ibyte_q;
  logic       ieoi_q;

  // Result register
  logic        ovalid_q, ovalid_d;
  logic [3:0]  okind_q;
  logic [7:0]  ochar_q;
  logic [15:0] opos_q;
  logic [7:0]  onum_q;
  logic [15:0] ostart_q;
  logic [15:0] osize_q;

  // Combinational result
  logic        has_res;
  logic [3:0]  rkind;
  logic [7:0]  rchar;
  logic [15:0] rpos;
  logic [7:0]  rnum;
  logic [15:0] rstart;
  logic [15:0] rsize;

  logic       out_space, fire, in_ready;
  logic [8:0] next_col, col_lim;
  logic       count_ok, pending;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q    <= csvs_pkg::SEPARATOR_RESET;
      expcol_q <= csvs_pkg::EXPECTED_COLUMNS_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        csvs_pkg::REG_SEPARATOR:        sep_q    <= cfg_i.wdata[7:0];
        csvs_pkg::REG_EXPECTED_COLUMNS: expcol_q <= cfg_i.wdata[8:0];
        default: ;
      endcase
    end
  end

  // Handshake glue
  assign out_space = !ovalid_q || out_o.ready;
  assign fire      = ivalid_q && (!has_res || out_space);
  assign in_ready  = !ivalid_q || fire;
  assign in_i.ready = in_ready;
  assign ivalid_d  = in_ready ? in_i.valid : ivalid_q;

  // Column checks: limit is min(expected, cap)
  assign next_col = {1'b0, field_q} + 9'd1;
  assign col_lim  = (expcol_q > csvs_pkg::COL_LIMIT_MAX) ? csvs_pkg::COL_LIMIT_MAX : expcol_q;
  assign count_ok = (next_col == expcol_q);
  assign pending  = (field_q != 8'd0) || (wpos_q != 16'd0) || inq_q;

  always_comb begin
    logic do_store;
    logic do_clear;
    do_store = 1'b0;
    do_clear = 1'b0;
    inq_d    = inq_q;
    field_d  = field_q;
    flen_d   = flen_q;
    fstart_d = fstart_q;
    wpos_d   = wpos_q;
    has_res  = 1'b0;
    rkind    = csvs_pkg::KIND_DATA;
    rchar    = 8'd0;
    rpos     = 16'd0;
    rnum     = 8'd0;
    rstart   = 16'd0;
    rsize    = 16'd0;

    if (ieoi_q) begin
      has_res  = 1'b1;
      rkind    = (!pending || (!inq_q && count_ok)) ? csvs_pkg::KIND_EOF_OK
                                                    : csvs_pkg::KIND_EOF_BAD;
      rnum     = field_q;
      rstart   = fstart_q;
      rsize    = flen_q;
      do_clear = 1'b1;
    end else if (inq_q) begin
      if (ibyte_q == csvs_pkg::CH_QUOTE) begin
        inq_d = 1'b0;
      end else if (ibyte_q == csvs_pkg::CH_NL) begin
        has_res  = 1'b1;
        rkind    = csvs_pkg::KIND_NL_QUOTE;
        do_clear = 1'b1;
      end else if (ibyte_q != csvs_pkg::CH_CR) begin
        do_store = 1'b1;
      end
    end else if (ibyte_q == csvs_pkg::CH_QUOTE && flen_q == 16'd0) begin
      inq_d = 1'b1;
    end else if (ibyte_q == csvs_pkg::CH_NL) begin
      has_res  = 1'b1;
      rkind    = count_ok ? csvs_pkg::KIND_LINE_OK : csvs_pkg::KIND_LINE_BAD;
      rnum     = field_q;
      rstart   = fstart_q;
      rsize    = flen_q;
      do_clear = 1'b1;
    end else if (ibyte_q == sep_q) begin
      has_res = 1'b1;
      if (next_col >= col_lim) begin
        // too many columns: column check comes before any position update
        rkind    = csvs_pkg::KIND_TOO_MANY;
        do_clear = 1'b1;
      end else begin
        rkind    = csvs_pkg::KIND_FIELD_END;
        rnum     = field_q;
        rstart   = fstart_q;
        rsize    = flen_q;
        field_d  = next_col[7:0];
        fstart_d = wpos_q;
        flen_d   = 16'd0;
      end
    end else if (ibyte_q != csvs_pkg::CH_CR) begin
      do_store = 1'b1;
    end

    if (do_store) begin
      has_res = 1'b1;
      if (wpos_q >= csvs_pkg::STORE_LIMIT) begin
        rkind    = csvs_pkg::KIND_TOO_LONG;
        do_clear = 1'b1;
      end else begin
        rkind  = csvs_pkg::KIND_DATA;
        rchar  = ibyte_q;
        rpos   = wpos_q;
        wpos_d = wpos_q + 16'd1;
        flen_d = flen_q + 16'd1;
      end
    end

    if (do_clear) begin
      inq_d    = 1'b0;
      field_d  = 8'd0;
      flen_d   = 16'd0;
      fstart_d = 16'd0;
      wpos_d   = 16'd0;
    end
  end

  assign ovalid_d = (fire && has_res) ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q <= 1'b0;
      ovalid_q <= 1'b0;
      inq_q    <= 1'b0;
      field_q  <= 8'd0;
      flen_q   <= 16'd0;
      fstart_q <= 16'd0;
      wpos_q   <= 16'd0;
    end else begin
      ivalid_q <= ivalid_d;
      ovalid_q <= ovalid_d;
      if (fire) begin
        inq_q    <= inq_d;
        field_q  <= field_d;
        flen_q   <= flen_d;
        fstart_q <= fstart_d;
        wpos_q   <= wpos_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      ibyte_q <= in_i.data_byte;
      ieoi_q  <= in_i.end_of_input;
    end
    if (fire && has_res) begin
      okind_q  <= rkind;
      ochar_q  <= rchar;
      opos_q   <= rpos;
      onum_q   <= rnum;
      ostart_q <= rstart;
      osize_q  <= rsize;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.kind          = okind_q;
  assign out_o.char_value    = ochar_q;
  assign out_o.line_position = opos_q;
  assign out_o.field_number  = onum_q;
  assign out_o.field_start   = ostart_q;
  assign out_o.field_size    = osize_q;

  // Store position never runs past capacity.
  `CSVS_ASSERT_IMPL(a_wpos_cap, clk_i, rst_ni, 1'b1, wpos_q <= csvs_pkg::STORE_LIMIT, "write position over capacity")
  // Open field always ends at the write position.
  `CSVS_ASSERT_IMPL(a_field_span, clk_i, rst_ni, 1'b1, (({1'b0, fstart_q} + {1'b0, flen_q}) == {1'b0, wpos_q}), "field start plus length differs from write position")
  // Line ends and errors leave a cleared line state.
  `CSVS_ASSERT_NEXT(a_clear, clk_i, rst_ni, fire && has_res && (rkind >= csvs_pkg::KIND_LINE_OK), !inq_q && field_q == 8'd0 && wpos_q == 16'd0, "line state not cleared")

endmodule

// ===== tb/tb_csv_field_splitter_core.sv =====
// Self-checking testbench of csv_field_splitter_core: directed and random byte streams.
module tb_csv_field_splitter_core;
  import csvs_pkg::*;

  // Settle time after the last expected word: drain of the input and result
  // registers plus slack for quote/CR words that retire without a result.
  localparam int SETTLE_CYCLES = 6;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT    = 2000;
  // Least number of result words per random phase.
  localparam int PHASE_RESULTS = 35;
  localparam int NUM_PHASES    = 10;

  // One result word as the block reports it.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  char_value;
    logic [15:0] line_position;
    logic [7:0]  field_number;
    logic [15:0] field_start;
    logic [15:0] field_size;
  } split_res_t;

  // Tracks the line state of the splitter and holds the words it must emit.
  class split_scoreboard;
    logic [7:0]  sep;
    logic [8:0]  cols;
    logic        quoted;
    logic [7:0]  field_idx;
    logic [15:0] field_len;
    logic [15:0] field_base;
    logic [15:0] wr_pos;
    split_res_t  pending_results[$];
    int          failures;
    int          words_in;
    int          results_predicted;
    int          results_checked;
    int          kind_count[9];

    function new();
      sep  = SEPARATOR_RESET;
      cols = EXPECTED_COLUMNS_RESET;
      clear_line();
    endfunction

    function void clear_line();
      quoted     = 1'b0;
      field_idx  = '0;
      field_len  = '0;
      field_base = '0;
      wr_pos     = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_SEPARATOR) sep = val[7:0];
      else if (idx == REG_EXPECTED_COLUMNS) cols = val;
    endfunction

    // Data byte into the line store; overflow drops the line.
    function void store_byte(logic [7:0] b, output split_res_t r);
      r = '0;
      if (int'(wr_pos) >= int'(STORE_LIMIT)) begin
        r.kind = KIND_TOO_LONG;
        clear_line();
      end else begin
        r.kind          = KIND_DATA;
        r.char_value    = b;
        r.line_position = wr_pos;
        wr_pos          = wr_pos + 16'd1;
        field_len       = field_len + 16'd1;
      end
    endfunction

    // Works out the result (if any) of one accepted input word.
    function void note_word(logic [7:0] b, logic eoi);
      split_res_t r;
      bit         emits;
      bit         busy;
      int         nxt;
      int         col_lim;
      r     = '0;
      emits = 1'b1;
      words_in++;
      if (eoi) begin
        busy    = (field_idx != 0) || (wr_pos != 0) || quoted;
        r.kind  = (!busy || (!quoted && int'(field_idx) + 1 == int'(cols))) ?
                  KIND_EOF_OK : KIND_EOF_BAD;
        r.field_number = field_idx;
        r.field_start  = field_base;
        r.field_size   = field_len;
        clear_line();
      end else if (quoted) begin
        if (b == CH_QUOTE) begin
          quoted = 1'b0;
          emits  = 1'b0;
        end else if (b == CH_NL) begin
          r.kind = KIND_NL_QUOTE;
          clear_line();
        end else if (b == CH_CR) begin
          emits = 1'b0;
        end else begin
          store_byte(b, r);
        end
      end else if (b == CH_QUOTE && field_len == 0) begin
        quoted = 1'b1;
        emits  = 1'b0;
      end else if (b == CH_NL) begin
        r.kind = (int'(field_idx) + 1 == int'(cols)) ? KIND_LINE_OK : KIND_LINE_BAD;
        r.field_number = field_idx;
        r.field_start  = field_base;
        r.field_size   = field_len;
        clear_line();
      end else if (b == sep) begin
        nxt     = int'(field_idx) + 1;
        col_lim = (int'(cols) < int'(COL_LIMIT_MAX)) ? int'(cols) : int'(COL_LIMIT_MAX);
        if (nxt >= col_lim) begin
          r.kind = KIND_TOO_MANY;
          clear_line();
        end else begin
          r.kind         = KIND_FIELD_END;
          r.field_number = field_idx;
          r.field_start  = field_base;
          r.field_size   = field_len;
          field_idx      = nxt[7:0];
          field_base     = wr_pos;
          field_len      = '0;
        end
      end else if (b == CH_CR) begin
        emits = 1'b0;
      end else begin
        store_byte(b, r);
      end
      if (emits) begin
        pending_results.push_back(r);
        results_predicted++;
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(split_res_t got);
      split_res_t want;
      if (pending_results.size() == 0) begin
        $error("result word of kind %0d arrived with nothing expected", got.kind);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", int'(want.kind), int'(got.kind));
      compare_field("char_value", int'(want.char_value), int'(got.char_value));
      compare_field("line_position", int'(want.line_position), int'(got.line_position));
      compare_field("field_number", int'(want.field_number), int'(got.field_number));
      compare_field("field_start", int'(want.field_start), int'(got.field_start));
      compare_field("field_size", int'(want.field_size), int'(got.field_size));
      results_checked++;
      if (int'(got.kind) < 9) kind_count[got.kind]++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  csvs_in_if  in_ch ();
  csvs_out_if out_ch ();
  csvs_cfg_if cfg_ch ();

  csv_field_splitter_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  split_scoreboard tracker;
  int tx_burst_left;    // words left in a no-gap stretch
  int settings_applied;

  // Mostly back-to-back or short gaps, with rare long ones and gap-free stretches.
  function automatic int tx_gap();
    int r;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random payload byte; plain (unquoted) fields avoid every special byte,
  // quoted ones may also carry the separator.
  function automatic logic [7:0] field_byte(bit in_quote);
    logic [7:0] b;
    if (in_quote && $urandom_range(0, 4) == 0) return tracker.sep;
    b = 8'($urandom_range(0, 255));
    while (b == CH_NL || b == CH_QUOTE || b == CH_CR || b == tracker.sep)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Present one word and hold it until the splitter takes it.
  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_word(b, eoi);
    gap = tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every expected word is back, then let quote/CR words drain.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers back to back; valid stays high across the two writes.
  task automatic apply_config(logic [7:0] sep, logic [8:0] cols);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_SEPARATOR;
    cfg_ch.wdata     <= {1'b0, sep};
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.write_reg(REG_SEPARATOR, {1'b0, sep});
    cfg_ch.reg_index <= REG_EXPECTED_COLUMNS;
    cfg_ch.wdata     <= cols;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.write_reg(REG_EXPECTED_COLUMNS, cols);
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Mostly well-formed line with random content; field count near the setting.
  // Wide lines carry bare empty fields so the run stays short.
  task automatic send_line();
    int nf;
    int flen;
    int r;
    bit q;
    if (tracker.cols == 0) nf = $urandom_range(1, 3);
    else if (tracker.cols > 256) nf = $urandom_range(256, 257);
    else nf = int'(tracker.cols);
    r = $urandom_range(0, 9);
    if (r == 0) nf++;
    else if (r == 1 && nf > 1) nf--;
    for (int f = 0; f < nf; f++) begin
      q    = (nf <= 8) && ($urandom_range(0, 3) == 0);
      flen = (nf > 8) ? 0 : $urandom_range(0, 6);
      if (q) send_word(CH_QUOTE, 1'b0);
      repeat (flen) send_word(field_byte(q), 1'b0);
      if (q) send_word(CH_QUOTE, 1'b0);
      if (f != nf - 1) send_word(tracker.sep, 1'b0);
    end
    if ($urandom_range(0, 5) == 0) send_word(CH_CR, 1'b0);
    send_word(CH_NL, 1'b0);
  endtask

  // Noise biased toward the bytes that steer the state machine.
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0:       send_word(CH_QUOTE, 1'b0);
      1:       send_word(CH_NL, 1'b0);
      2:       send_word(CH_CR, 1'b0);
      3:       send_word(tracker.sep, 1'b0);
      4:       send_word(8'($urandom_range(0, 255)), 1'b1);
      default: send_word(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  task automatic run_random_phase();
    int start;
    int r;
    start = tracker.results_predicted;
    while (tracker.results_predicted - start < PHASE_RESULTS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_line();
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6)) send_noise();
      end else if (r < 98) begin
        // line cut short by end of stream
        repeat ($urandom_range(0, 4)) send_word(field_byte(1'b0), 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        quiesce();
      end
    end
  endtask

  // Result side: check every accepted word, then pick the next ready level.
  initial begin : result_sink
    int hold;
    int r;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_ch.valid && out_ch.ready)
        tracker.check_result({out_ch.kind, out_ch.char_value, out_ch.line_position,
                              out_ch.field_number, out_ch.field_start, out_ch.field_size});
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 17) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else if (r < 19) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end else begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(30, 80);
        end
      end
    end
  end

  // Hang detector: any accepted word on any channel resets the count.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no word moved for %0d cycles", HANG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_sep[NUM_PHASES];
    logic [8:0] phase_cols[NUM_PHASES];
    // Separators include the special bytes (quote, CR, newline) and both ends
    // of the byte range; column counts include zero, one, the 256 cap and 511.
    phase_sep  = '{8'd44, 8'd9, CH_QUOTE, CH_CR, CH_NL, 8'd0, 8'd255, 8'd59, 8'd0, 8'd124};
    phase_cols = '{9'd3, 9'd1, 9'd2, 9'd4, 9'd2, 9'd256, 9'd0, 9'd511, 9'd0, 9'd5};
    tracker          = new();
    tx_burst_left    = 0;
    settings_applied = 0;

    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= '0;
    in_ch.end_of_input <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= REG_SEPARATOR;
    cfg_ch.wdata       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed: reset settings (comma, one column) ----
    send_word(8'h00, 1'b1);        // end of stream, nothing pending
    send_word(8'h61, 1'b0);        // 'a'
    send_word(CH_NL, 1'b0);        // one field, matches
    quiesce();
    apply_config(8'd44, 9'd3);

    // quoted field holding separator and CR, then a quote stored as data
    send_word(CH_QUOTE, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'd44, 1'b0);        // separator is data inside quotes
    send_word(CH_CR, 1'b0);        // dropped inside quotes
    send_word(8'h62, 1'b0);
    send_word(CH_QUOTE, 1'b0);     // closes quotes
    send_word(CH_CR, 1'b0);        // dropped outside quotes
    send_word(CH_QUOTE, 1'b0);     // field already has data: stored
    send_word(8'd44, 1'b0);
    send_word(8'h00, 1'b0);        // byte extremes
    send_word(8'hFF, 1'b0);
    send_word(8'd44, 1'b0);
    send_word(CH_NL, 1'b0);        // three fields: line ok
    // too many columns
    send_word(8'd44, 1'b0);
    send_word(8'd44, 1'b0);
    send_word(8'd44, 1'b0);
    // newline inside quotes
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_NL, 1'b0);
    // pending line with wrong count at end of stream, then nothing pending
    send_word(8'h7A, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(CH_NL, 1'b0);        // single empty field: bad count
    quiesce();

    // ---- random phases, one register setting each ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 8) begin
        phase_sep[p]  = 8'($urandom_range(0, 255));
        phase_cols[p] = 9'($urandom_range(1, 6));
      end
      apply_config(phase_sep[p], phase_cols[p]);
      run_random_phase();
      quiesce();
    end

    // quiesce already waited out the pipeline; anything left never came
    if (tracker.pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", tracker.pending_results.size());
      tracker.failures++;
    end
    $display("run covered %0d input words, %0d result words checked, %0d register settings",
             tracker.words_in, tracker.results_checked, settings_applied);
    $display({"kinds data/field/ok/bad/nlq/many/long/eof_ok/eof_bad:",
              " %0d %0d %0d %0d %0d %0d %0d %0d %0d"},
             tracker.kind_count[0], tracker.kind_count[1], tracker.kind_count[2],
             tracker.kind_count[3], tracker.kind_count[4], tracker.kind_count[5],
             tracker.kind_count[6], tracker.kind_count[7], tracker.kind_count[8]);
    if (tracker.failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
